// File: rtl/kos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kos_pkg
// Shared types, widths and register indexes for the streaming k-th order
// statistic block.
// ----------------------------------------------------------------------------
package kos_pkg;

	localparam int VALUE_W      = 32;
	localparam int KEEP_W       = 5;
	localparam int MAX_KEEP_DEF = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 2'd1;

	localparam logic MODE_LARGEST  = 1'b0;
	localparam logic MODE_SMALLEST = 1'b1;

	// one step request from the top level to the sorted row
	typedef struct packed {
		logic              fire;
		logic              set_end;
		logic              order_mode;
		logic [KEEP_W-1:0] keep_count;
	} kos_step_t;

endpackage : kos_pkg
`default_nettype wire

// File: rtl/kos_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kos_if
// Valid/ready channels: sample input, result output and configuration write.
// ----------------------------------------------------------------------------
interface kos_in_if
	import kos_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] sample_value;
	logic                      set_end;

	modport source (output valid, output sample_value, output set_end, input ready);
	modport sink   (input valid, input sample_value, input set_end, output ready);
endinterface : kos_in_if

interface kos_out_if
	import kos_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] kth_value;
	logic                      holds_k;
	logic                      result_end;

	modport source (output valid, output kth_value, output holds_k, output result_end,
		input ready);
	modport sink   (input valid, input kth_value, input holds_k, input result_end,
		output ready);
endinterface : kos_out_if

interface kos_cfg_if
	import kos_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface : kos_cfg_if
`default_nettype wire

// File: rtl/kos_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kos_row
// Sorted register row, best first, with a combinational compare-and-shift insert.
// ----------------------------------------------------------------------------
module kos_row
	import kos_pkg::*;
#(
	parameter int MAX_KEEP = MAX_KEEP_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire kos_step_t                 step,
	input  wire logic signed [VALUE_W-1:0] sample_value,
	output logic signed [VALUE_W-1:0]      kth_value,
	output logic                           holds_k
);

	localparam int CW = $clog2(MAX_KEEP + 1);
	localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int WW = (CW > KEEP_W) ? CW : KEEP_W;

	logic signed [VALUE_W-1:0] row_q [MAX_KEEP];
	logic [CW-1:0]             held_q;

	logic [WW-1:0]             kc_w;
	logic [WW-1:0]             k_w;
	logic [CW-1:0]             k_eff;
	logic [CW-1:0]             held;
	logic                      room;
	logic [MAX_KEEP-1:0]       better;
	logic [MAX_KEEP-1:0]       first;
	logic [MAX_KEEP-1:0]       below;
	logic                      any_better;
	logic                      do_ins;
	logic signed [VALUE_W-1:0] row_d [MAX_KEEP];
	logic [CW-1:0]             count_d;
	logic [CW-1:0]             last_idx;

	// clamp k to 1..MAX_KEEP
	always_comb begin
		kc_w = WW'(step.keep_count);
		if (kc_w == '0) begin
			k_w = WW'(1);
		end else if (kc_w > WW'(MAX_KEEP)) begin
			k_w = WW'(MAX_KEEP);
		end else begin
			k_w = kc_w;
		end
		k_eff = CW'(k_w);
		held  = (held_q > k_eff) ? k_eff : held_q;
		room  = held < k_eff;
	end

	// first held entry that the sample beats
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < MAX_KEEP; i++) begin
			if (step.order_mode == MODE_SMALLEST) begin
				better[i] = (CW'(i) < held) && (sample_value < row_q[i]);
			end else begin
				better[i] = (CW'(i) < held) && (sample_value > row_q[i]);
			end
			below[i] = seen;
			first[i] = better[i] & ~seen;
			seen     = seen | better[i];
		end
		any_better = seen;
		do_ins     = any_better | room;
	end

	always_comb begin
		for (int i = 0; i < MAX_KEEP; i++) begin
			if (first[i] || (!any_better && room && (CW'(i) == held))) begin
				row_d[i] = sample_value;
			end else if (below[i] && (i > 0)) begin
				row_d[i] = row_q[(i > 0) ? i - 1 : 0];
			end else begin
				row_d[i] = row_q[i];
			end
		end
		count_d  = room ? held + CW'(1) : held;
		last_idx = count_d - CW'(1);
	end

	assign kth_value = row_d[last_idx[IW-1:0]];
	assign holds_k   = count_d == k_eff;

	always_ff @(posedge clk) begin
		if (step.fire && do_ins) begin
			for (int i = 0; i < MAX_KEEP; i++) begin
				row_q[i] <= row_d[i];
			end
		end
	end

	// a set end empties the row for the next set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (step.fire) begin
			held_q <= step.set_end ? '0 : count_d;
		end
	end

endmodule : kos_row
`default_nettype wire

// File: rtl/streaming_kth_order_statistic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// streaming_kth_order_statistic
// Keeps the k largest or k smallest samples of a set and reports the k-th.
// ----------------------------------------------------------------------------
// Path: a sample is held in the input register, then its result in the result register.
// Throughput: one sample per cycle while the result sink is ready; the row compare-and-shift is combinational.
// Result stalls back up through the input register only when both stages are full.
// Reset: keep_count = 1, order_mode = largest, row empty, no result pending.
// Configuration writes are taken every cycle.
module streaming_kth_order_statistic
	import kos_pkg::*;
#(
	parameter int MAX_KEEP = MAX_KEEP_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kos_in_if.sink     samples,
	kos_out_if.source  results,
	kos_cfg_if.sink    cfg
);

	logic [KEEP_W-1:0]         keep_count_q;
	logic                      order_mode_q;

	logic                      valid_s1;
	logic signed [VALUE_W-1:0] sample_s1;
	logic                      end_s1;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] kth_q;
	logic                      holds_k_q;
	logic                      end_q;

	logic                      advance;
	logic                      fire;
	kos_step_t                 step;
	logic signed [VALUE_W-1:0] kth_d;
	logic                      holds_k_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_W'(1);
			order_mode_q <= MODE_LARGEST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KEEP_COUNT: keep_count_q <= cfg.data[KEEP_W-1:0];
				REG_ORDER_MODE: order_mode_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign advance       = !out_valid_q || results.ready;
	assign fire          = valid_s1 && advance;
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			sample_s1 <= samples.sample_value;
			end_s1    <= samples.set_end;
		end
	end

	always_comb begin
		step.fire       = fire;
		step.set_end    = end_s1;
		step.order_mode = order_mode_q;
		step.keep_count = keep_count_q;
	end

	kos_row #(
		.MAX_KEEP(MAX_KEEP)
	) u_row (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.sample_value(sample_s1),
		.kth_value   (kth_d),
		.holds_k     (holds_k_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// hold the result while the sink stalls
	always_ff @(posedge clk) begin
		if (fire) begin
			kth_q     <= kth_d;
			holds_k_q <= holds_k_d;
			end_q     <= end_s1;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.kth_value  = kth_q;
	assign results.holds_k    = holds_k_q;
	assign results.result_end = end_q;

endmodule : streaming_kth_order_statistic
`default_nettype wire

// File: rtl/kos_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kos_checker
// Port-level checks on the k-th order statistic block, bound to its top level.
// ----------------------------------------------------------------------------
module kos_checker
	import kos_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic signed [VALUE_W-1:0] out_kth_value,
	input wire logic                      cfg_valid,
	input wire logic                      cfg_ready
);

	// a stalled result stays offered with the same value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kth_value))
		else $error("result dropped or changed while stalled");

	// a sink that takes results never throttles the sample side
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("sample side stalled while results drain");

	// with nothing pending, samples are always taken
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(in_valid && in_ready) |-> in_ready)
		else $error("sample side stalled while empty");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule : kos_checker

bind streaming_kth_order_statistic kos_checker u_kos_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_kth_value(results.kth_value),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready)
);
`default_nettype wire

// File: tb/sv/streaming_kth_order_statistic_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// streaming_kth_order_statistic_tb
// Drives sample sets through the k-th order statistic block under random
// backpressure and checks every result against a sorted-row predictor. The
// keep count and order mode change between phases, sometimes mid-set.
// ----------------------------------------------------------------------------
module streaming_kth_order_statistic_tb;
	import kos_pkg::*;

	localparam int MAX_KEEP   = MAX_KEEP_DEF;
	localparam int IDLE_PCT   = 8;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD  = 120;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} sample_req_t;

	typedef struct {
		logic signed [VALUE_W-1:0] kth;
		logic                      full;
		logic                      last;
	} kth_answer_t;

	logic clk;
	logic arst_n;

	kos_in_if  smp();
	kos_out_if res();
	kos_cfg_if cfg_bus();

	streaming_kth_order_statistic #(
		.MAX_KEEP(MAX_KEEP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp),
		.results (res),
		.cfg     (cfg_bus)
	);

	sample_req_t sample_backlog[$];
	kth_answer_t kth_expected[$];

	// predictor state
	logic [KEEP_W-1:0]         keep_cfg;
	logic                      mode_cfg;
	logic signed [VALUE_W-1:0] best_row [MAX_KEEP];
	int                        row_fill;

	int  errors;
	int  results_seen;
	int  hold_left;
	bit  long_hold_done;
	bit  steady;
	int  idle_cycles;
	int  set_left;

	always #4 clk = ~clk;

	function automatic bit beats(input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b);
		return (mode_cfg == MODE_SMALLEST) ? (a < b) : (a > b);
	endfunction

	// insert one sample into the sorted row and queue the answer it yields
	function automatic void rank_sample(input logic signed [VALUE_W-1:0] v,
		input logic last);
		int          k;
		int          pos;
		int          i;
		kth_answer_t ans;
		if (keep_cfg == 0)
			k = 1;
		else if (int'(keep_cfg) > MAX_KEEP)
			k = MAX_KEEP;
		else
			k = int'(keep_cfg);
		// a lowered k drops the worst entries first
		if (row_fill > k)
			row_fill = k;
		pos = row_fill;
		for (i = row_fill - 1; i >= 0; i--)
			if (beats(v, best_row[i]))
				pos = i;
		if (row_fill < k) begin
			for (i = row_fill; i > pos; i--)
				best_row[i] = best_row[i - 1];
			best_row[pos] = v;
			row_fill++;
		end else if (pos < row_fill) begin
			for (i = row_fill - 1; i > pos; i--)
				best_row[i] = best_row[i - 1];
			best_row[pos] = v;
		end
		ans.kth  = best_row[row_fill - 1];
		ans.full = (row_fill == k);
		ans.last = last;
		kth_expected.push_back(ans);
		if (last)
			row_fill = 0;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
		0: return 32'sh7fff_ffff;
		1: return 32'sh8000_0000;
		2, 3: return int'($urandom_range(0, 16)) - 8;
		default: return $urandom;
		endcase
	endfunction

	function automatic int next_set_len();
		case ($urandom_range(0, 7))
		0: return 1;
		1: return $urandom_range(20, 60);
		default: return $urandom_range(2, 20);
		endcase
	endfunction

	// sets run on across phases, so config changes also land mid-set
	function automatic void queue_random_samples(input int n);
		sample_req_t req;
		repeat (n) begin
			if (set_left == 0)
				set_left = next_set_len();
			req.value = pick_sample();
			req.last  = (set_left == 1);
			set_left--;
			sample_backlog.push_back(req);
		end
	endfunction

	function automatic void queue_sample(input logic signed [VALUE_W-1:0] v,
		input logic last);
		sample_req_t req;
		req.value = v;
		req.last  = last;
		sample_backlog.push_back(req);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		if (idx == REG_KEEP_COUNT)
			keep_cfg = val[KEEP_W-1:0];
		else if (idx == REG_ORDER_MODE)
			mode_cfg = val[0];
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic drain();
		while (sample_backlog.size() != 0 || kth_expected.size() != 0 || smp.valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
		end else begin
			if (smp.valid && smp.ready)
				rank_sample(smp.sample_value, smp.set_end);
			if (!smp.valid || smp.ready) begin
				if (sample_backlog.size() != 0 &&
					(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					smp.valid        <= 1'b1;
					smp.sample_value <= sample_backlog[0].value;
					smp.set_end      <= sample_backlog[0].last;
					void'(sample_backlog.pop_front());
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		kth_answer_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				results_seen++;
				if (kth_expected.size() == 0) begin
					$error("result with no request pending: kth_value %0d", res.kth_value);
					errors++;
				end else begin
					want = kth_expected.pop_front();
					if (res.kth_value !== want.kth) begin
						$error("kth_value: expected %0d, got %0d", want.kth, res.kth_value);
						errors++;
					end
					if (res.holds_k !== want.full) begin
						$error("holds_k: expected %0b, got %0b", want.full, res.holds_k);
						errors++;
					end
					if (res.result_end !== want.last) begin
						$error("result_end: expected %0b, got %0b", want.last,
							res.result_end);
						errors++;
					end
				end
			end
			// hold off once for a long stretch so the input backs up
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 300) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD;
				res.ready      <= 1'b0;
			end else begin
				res.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((smp.valid && smp.ready) || (res.valid && res.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int k_pick;
		clk              = 1'b0;
		arst_n           = 1'b0;
		smp.valid        = 1'b0;
		smp.sample_value = '0;
		smp.set_end      = 1'b0;
		res.ready        = 1'b0;
		cfg_bus.valid    = 1'b0;
		cfg_bus.index    = REG_KEEP_COUNT;
		cfg_bus.data     = '0;
		keep_cfg         = 5'd1;
		mode_cfg         = MODE_LARGEST;
		row_fill         = 0;
		errors           = 0;
		results_seen     = 0;
		hold_left        = 0;
		long_hold_done   = 1'b0;
		steady           = 1'b0;
		idle_cycles      = 0;
		set_left         = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset config: keep the single largest
		queue_sample(0, 1'b0);
		queue_sample(32'sh7fff_ffff, 1'b0);
		queue_sample(32'sh8000_0000, 1'b0);
		queue_sample(-1, 1'b1);
		drain();

		// equal samples never displace the worst held one
		write_reg(REG_KEEP_COUNT, 5'd3);
		queue_sample(5, 1'b0);
		queue_sample(5, 1'b0);
		queue_sample(5, 1'b0);
		queue_sample(2, 1'b0);
		queue_sample(9, 1'b0);
		queue_sample(32'sh8000_0000, 1'b1);
		drain();

		// zero k acts as one, oversized k clamps to the row depth
		write_reg(REG_KEEP_COUNT, 5'd0);
		queue_sample(10, 1'b0);
		queue_sample(-3, 1'b1);
		drain();
		write_reg(REG_KEEP_COUNT, 5'd31);
		queue_sample(1, 1'b0);
		queue_sample(2, 1'b0);
		queue_sample(3, 1'b0);
		drain();

		// lower k and flip the mode inside an open set
		write_reg(REG_KEEP_COUNT, 5'd2);
		write_reg(REG_ORDER_MODE, {4'd0, MODE_SMALLEST});
		queue_sample(0, 1'b0);
		queue_sample(32'sh7fff_ffff, 1'b0);
		queue_sample(32'sh8000_0000, 1'b1);
		drain();

		write_reg(REG_KEEP_COUNT, 5'd16);
		queue_sample(-1, 1'b0);
		queue_sample(32'sh7fff_ffff, 1'b0);
		queue_sample(32'sh8000_0000, 1'b0);
		queue_sample(-1, 1'b0);
		queue_sample(4, 1'b1);
		drain();

		for (int p = 0; p < 12; p++) begin
			case ($urandom_range(0, 9))
			0: k_pick = 0;
			1: k_pick = $urandom_range(17, 31);
			2: k_pick = 1;
			3: k_pick = MAX_KEEP;
			default: k_pick = $urandom_range(1, 16);
			endcase
			write_reg(REG_KEEP_COUNT, CFG_DATA_W'(k_pick));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_ORDER_MODE, {4'd0, 1'($urandom_range(0, 1))});
			steady = (p == 5);
			queue_random_samples(152);
			drain();
		end
		steady = 1'b0;

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule : streaming_kth_order_statistic_tb
`default_nettype wire

// File: files.f
rtl/kos_pkg.sv
rtl/kos_if.sv
rtl/kos_row.sv
rtl/streaming_kth_order_statistic.sv
rtl/kos_checker.sv
tb/sv/streaming_kth_order_statistic_tb.sv
